// ===== src/ffha_pkg.sv =====
// ffha_pkg: shared types and fixed constants of the first-fit heap allocator.
// Used by the interfaces, controller, datapath, top level and checker.
// No dependencies.
package ffha_pkg;

	localparam int ADDR_W        = 48;
	localparam int REQ_W         = 21;
	localparam int SIZE_W        = 22;
	localparam int PCFG_W        = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 48;
	localparam int PAGE_BYTES    = 4096;
	localparam int PAGE_SHIFT    = 12;
	localparam int GRANULE_BYTES = 16;
	localparam int GRANULE_SHIFT = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PAGES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAGES     = 2'd2;

	typedef enum logic [2:0] {
		RES_ALLOCATED   = 3'd0,
		RES_RELEASED    = 3'd1,
		RES_ZERO_SIZE   = 3'd2,
		RES_NO_MEMORY   = 3'd3,
		RES_BAD_ADDRESS = 3'd4
	} res_code_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_ACCEPT,
		OP_SCAN,
		OP_GROW_RD,
		OP_GROW,
		OP_RESCAN,
		OP_HIT,
		OP_UP_RD,
		OP_UP_WR,
		OP_SPLIT_WR,
		OP_ALLOC_WR,
		OP_NEXT_RD,
		OP_NEXT_MERGE,
		OP_DN_RD,
		OP_DN_WR,
		OP_DN_END,
		OP_PREV_RD,
		OP_PREV_MERGE,
		OP_REL_WR,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t       op;
		res_code_t code;
	} cmd_t;

	typedef struct packed {
		logic pend;
		logic release_op;
		logic size_zero;
		logic hit;
		logic at_last;
		logic grow_ok;
		logic split;
		logic up_done;
		logic dn_done;
		logic has_next;
		logic has_prev;
		logic nb_free;
		logic out_free;
	} stat_t;

endpackage

// ===== src/ffha_if.sv =====
// ffha_if: request and response channel interfaces of the heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [ffha_pkg::REQ_W-1:0]    request_size;
	logic [ffha_pkg::ADDR_W-1:0]   release_address;
	modport source (output valid, mode, request_size, release_address, input ready);
	modport sink (input valid, mode, request_size, release_address, output ready);
endinterface

interface ffha_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffha_pkg::ADDR_W-1:0]   block_address;
	logic [2:0]                    status;
	modport source (output valid, block_address, status, input ready);
	modport sink (input valid, block_address, status, output ready);
endinterface

// ===== src/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: one item at a time. Allocation scans the table at one entry
// per cycle; when nothing fits it takes a growth step (read the last entry, grow, then
// rescan from entry 0), and a split shifts the entries above the hit up by one, each
// with a read and a write. Release scans likewise, then each coalesce shifts the entries
// behind it down by one. The table has one read and one write port; rsp may stall the end.
// After reset or a heap_base/initial_pages write, entry 0 is rewritten first.
module first_fit_heap_allocator #(
	parameter int MAX_PAGES    = 256,
	parameter int MAX_SEGMENTS = 256,
	parameter int HEADER_BYTES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ffha_req_if.sink                         req,
	ffha_rsp_if.source                       rsp,
	input  logic                             cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0]  cfg_data
);
	// command word from the sequencer, status word back from the datapath
	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;

	// the sequencer owns the request handshake; it opens only when idle
	ffha_ctrl u_ffha_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// the datapath holds the table, configuration and the result register,
	// so a finished word can wait on rsp while the next request is taken
	ffha_dp #(
		.MAX_PAGES    (MAX_PAGES),
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_ffha_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_mode    (req.mode),
		.in_size    (req.request_size),
		.in_addr    (req.release_address),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_addr   (rsp.block_address),
		.out_status (rsp.status)
	);
endmodule

// ===== src/ffha_ram.sv =====
// ffha_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffha_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/ffha_ctrl.sv =====
// ffha_ctrl: sequencing state machine of the heap allocator.
// Depends on ffha_pkg for command and status types.
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffha_pkg::stat_t stat,
	output ffha_pkg::cmd_t  cmd
);
	typedef enum logic [17:0] {
		S_IDLE     = 18'h00001,
		S_SCAN     = 18'h00002,
		S_GROW_RD  = 18'h00004,
		S_GROW     = 18'h00008,
		S_RESCAN   = 18'h00010,
		S_HIT      = 18'h00020,
		S_UP_RD    = 18'h00040,
		S_UP_WR    = 18'h00080,
		S_SPLIT_WR = 18'h00100,
		S_ALLOC_WR = 18'h00200,
		S_NEXT_RD  = 18'h00400,
		S_NEXT     = 18'h00800,
		S_DN_RD    = 18'h01000,
		S_DN_WR    = 18'h02000,
		S_PREV_RD  = 18'h04000,
		S_PREV     = 18'h08000,
		S_REL_WR   = 18'h10000,
		S_EMIT     = 18'h20000
	} state_t;

	state_t              state_q, state_d;
	ffha_pkg::res_code_t code_q, code_d;
	logic                second_q, second_d;

	assign in_ready = (state_q == S_IDLE) && !stat.pend;

	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		second_d = second_q;
		cmd.op   = ffha_pkg::OP_NONE;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (stat.pend) begin
					cmd.op = ffha_pkg::OP_INIT;
				end else if (in_valid) begin
					cmd.op  = ffha_pkg::OP_ACCEPT;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.op = ffha_pkg::OP_SCAN;
				priority if (!stat.release_op && stat.size_zero) begin
					code_d  = ffha_pkg::RES_ZERO_SIZE;
					state_d = S_EMIT;
				end else if (stat.hit) begin
					state_d = stat.release_op ? S_NEXT_RD : S_HIT;
				end else if (stat.at_last) begin
					if (stat.release_op) begin
						code_d  = ffha_pkg::RES_BAD_ADDRESS;
						state_d = S_EMIT;
					end else begin
						state_d = S_GROW_RD;
					end
				end
			end
			S_GROW_RD: begin
				cmd.op  = ffha_pkg::OP_GROW_RD;
				state_d = S_GROW;
			end
			S_GROW: begin
				cmd.op = ffha_pkg::OP_GROW;
				if (stat.grow_ok) begin
					state_d = S_RESCAN;
				end else begin
					code_d  = ffha_pkg::RES_NO_MEMORY;
					state_d = S_EMIT;
				end
			end
			S_RESCAN: begin
				cmd.op  = ffha_pkg::OP_RESCAN;
				state_d = S_SCAN;
			end
			S_HIT: begin
				cmd.op  = ffha_pkg::OP_HIT;
				state_d = stat.split ? S_UP_RD : S_ALLOC_WR;
			end
			S_UP_RD: begin
				if (stat.up_done) begin
					state_d = S_SPLIT_WR;
				end else begin
					cmd.op  = ffha_pkg::OP_UP_RD;
					state_d = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.op  = ffha_pkg::OP_UP_WR;
				state_d = S_UP_RD;
			end
			S_SPLIT_WR: begin
				cmd.op  = ffha_pkg::OP_SPLIT_WR;
				state_d = S_ALLOC_WR;
			end
			S_ALLOC_WR: begin
				cmd.op  = ffha_pkg::OP_ALLOC_WR;
				code_d  = ffha_pkg::RES_ALLOCATED;
				state_d = S_EMIT;
			end
			S_NEXT_RD: begin
				if (stat.has_next) begin
					cmd.op  = ffha_pkg::OP_NEXT_RD;
					state_d = S_NEXT;
				end else begin
					state_d = S_PREV_RD;
				end
			end
			S_NEXT: begin
				cmd.op   = ffha_pkg::OP_NEXT_MERGE;
				second_d = 1'b0;
				state_d  = stat.nb_free ? S_DN_RD : S_PREV_RD;
			end
			S_DN_RD: begin
				if (stat.dn_done) begin
					cmd.op = ffha_pkg::OP_DN_END;
					if (second_q) begin
						code_d  = ffha_pkg::RES_RELEASED;
						state_d = S_EMIT;
					end else begin
						state_d = S_PREV_RD;
					end
				end else begin
					cmd.op  = ffha_pkg::OP_DN_RD;
					state_d = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.op  = ffha_pkg::OP_DN_WR;
				state_d = S_DN_RD;
			end
			S_PREV_RD: begin
				if (stat.has_prev) begin
					cmd.op  = ffha_pkg::OP_PREV_RD;
					state_d = S_PREV;
				end else begin
					state_d = S_REL_WR;
				end
			end
			S_PREV: begin
				cmd.op   = ffha_pkg::OP_PREV_MERGE;
				second_d = 1'b1;
				state_d  = stat.nb_free ? S_DN_RD : S_REL_WR;
			end
			S_REL_WR: begin
				cmd.op  = ffha_pkg::OP_REL_WR;
				code_d  = ffha_pkg::RES_RELEASED;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.op = ffha_pkg::OP_EMIT;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			code_q   <= ffha_pkg::RES_ALLOCATED;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			code_q   <= code_d;
			second_q <= second_d;
		end
	end
endmodule

// ===== src/ffha_dp.sv =====
// ffha_dp: segment table, configuration, arithmetic and result register.
// Depends on ffha_pkg and ffha_ram; driven by ffha_ctrl commands.
module ffha_dp #(
	parameter int MAX_PAGES    = 256,
	parameter int MAX_SEGMENTS = 256,
	parameter int HEADER_BYTES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ffha_pkg::cmd_t                      cmd,
	output ffha_pkg::stat_t                     stat,
	input  logic                                cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_mode,
	input  logic [ffha_pkg::REQ_W-1:0]          in_size,
	input  logic [ffha_pkg::ADDR_W-1:0]         in_addr,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [ffha_pkg::ADDR_W-1:0]         out_addr,
	output logic [2:0]                          out_status
);
	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int BW   = $clog2(MAX_PAGES * ffha_pkg::PAGE_BYTES);
	localparam int PW   = $clog2(MAX_PAGES + 1);
	localparam int GPW  = ffha_pkg::SIZE_W - ffha_pkg::PAGE_SHIFT;
	localparam int KW   = ((PW > GPW) ? PW : GPW) + 1;
	localparam int XW   = ((BW > ffha_pkg::SIZE_W) ? BW : ffha_pkg::SIZE_W) + 2;
	localparam int EW   = 2 * BW + 1;
	localparam int AW   = ffha_pkg::ADDR_W;
	localparam int SW   = ffha_pkg::SIZE_W;
	localparam int PCW  = ffha_pkg::PCFG_W;

	logic          we;
	logic [IW-1:0] raddr, waddr;
	logic [EW-1:0] wdata, rdata;
	logic [BW-1:0] rd_off, rd_len;
	logic          rd_free;

	logic          mode_q, split_q, pend_q;
	logic [SW-1:0] size_q;
	logic [GPW-1:0] gp_q;
	logic [AW-1:0] tgt_q, base_h_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] ptr_q, count_q;
	logic [BW-1:0] cur_off_q, cur_len_q;
	logic [PW-1:0] pages_q;
	logic [PCW-1:0] init_q, max_q;
	logic          out_valid_q;
	logic [AW-1:0] out_addr_q;
	logic [2:0]    out_status_q;

	logic [CW-1:0] idx_x, idx_p1;
	logic          seg_room;
	logic          reinit_wr;
	logic [KW-1:0] lim, ip_k;
	logic [PW-1:0] ip;
	logic [XW-1:0] gbytes, pbytes, ibytes;
	logic [SW-1:0] rsum, gsum;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ffha_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_off  = rdata[EW-1 -: BW];
	assign rd_len  = rdata[BW:1];
	assign rd_free = rdata[0];

	assign idx_x    = CW'(idx_q);
	assign idx_p1   = idx_x + CW'(1);
	assign seg_room = count_q < CW'(MAX_SEGMENTS);

	// a write that rebuilds the heap keeps the rebuild pending
	assign reinit_wr = cfg_we && ((cfg_index == ffha_pkg::CFG_HEAP_BASE) ||
		(cfg_index == ffha_pkg::CFG_INITIAL_PAGES));

	// page count clamps: zero counts as one, above the limit counts as the limit
	assign lim  = (max_q == '0) ? KW'(1) :
		((KW'(max_q) > KW'(MAX_PAGES)) ? KW'(MAX_PAGES) : KW'(max_q));
	assign ip_k = (init_q == '0) ? KW'(1) :
		((KW'(init_q) > KW'(MAX_PAGES)) ? KW'(MAX_PAGES) : KW'(init_q));
	assign ip   = ip_k[PW-1:0];

	assign gbytes = XW'(gp_q) << ffha_pkg::PAGE_SHIFT;
	assign pbytes = XW'(pages_q) << ffha_pkg::PAGE_SHIFT;
	assign ibytes = XW'(ip) << ffha_pkg::PAGE_SHIFT;

	assign rsum = SW'(in_size) + SW'(ffha_pkg::GRANULE_BYTES - 1);
	assign gsum = SW'(in_size) + SW'(ffha_pkg::PAGE_BYTES - 1);

	always_comb begin
		stat.pend       = pend_q;
		stat.release_op = mode_q;
		stat.size_zero  = (size_q == '0);
		stat.hit        = mode_q ?
			((rd_off == tgt_q[BW-1:0]) && (tgt_q[AW-1:BW] == '0)) :
			(rd_free && (XW'(rd_len) >= XW'(size_q)));
		stat.at_last    = (idx_p1 == count_q);
		stat.grow_ok    = ((KW'(pages_q) + KW'(gp_q)) <= lim) && (rd_free || seg_room);
		stat.split      = seg_room && (XW'(cur_len_q) >= (XW'(size_q) +
			XW'(HEADER_BYTES) + XW'(ffha_pkg::GRANULE_BYTES)));
		stat.up_done    = (ptr_q == idx_p1);
		stat.dn_done    = ((ptr_q + CW'(1)) == count_q);
		stat.has_next   = (idx_p1 < count_q);
		stat.has_prev   = (idx_q != '0);
		stat.nb_free    = rd_free;
		stat.out_free   = !out_valid_q || out_ready;
	end

	// table port selection
	always_comb begin
		raddr = idx_q;
		we    = 1'b0;
		waddr = idx_q;
		wdata = {cur_off_q, cur_len_q, 1'b1};
		unique case (cmd.op)
			ffha_pkg::OP_INIT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = {BW'(0), BW'(ibytes - XW'(HEADER_BYTES)), 1'b1};
			end
			ffha_pkg::OP_ACCEPT, ffha_pkg::OP_RESCAN: begin
				raddr = '0;
			end
			ffha_pkg::OP_SCAN, ffha_pkg::OP_NEXT_RD: begin
				raddr = idx_p1[IW-1:0];
			end
			ffha_pkg::OP_GROW_RD: begin
				raddr = IW'(count_q - CW'(1));
			end
			ffha_pkg::OP_GROW: begin
				if (stat.grow_ok) begin
					we = 1'b1;
					if (rd_free) begin
						waddr = IW'(count_q - CW'(1));
						wdata = {rd_off, BW'(XW'(rd_len) + gbytes), 1'b1};
					end else begin
						waddr = count_q[IW-1:0];
						wdata = {BW'(pbytes), BW'(gbytes - XW'(HEADER_BYTES)), 1'b1};
					end
				end
			end
			ffha_pkg::OP_UP_RD: begin
				raddr = IW'(ptr_q - CW'(1));
			end
			ffha_pkg::OP_UP_WR, ffha_pkg::OP_DN_WR: begin
				we    = 1'b1;
				waddr = ptr_q[IW-1:0];
				wdata = rdata;
			end
			ffha_pkg::OP_SPLIT_WR: begin
				we    = 1'b1;
				waddr = idx_p1[IW-1:0];
				wdata = {BW'(XW'(cur_off_q) + XW'(HEADER_BYTES) + XW'(size_q)),
					BW'(XW'(cur_len_q) - XW'(size_q) - XW'(HEADER_BYTES)), 1'b1};
			end
			ffha_pkg::OP_ALLOC_WR: begin
				we    = 1'b1;
				wdata = {cur_off_q, split_q ? BW'(size_q) : cur_len_q, 1'b0};
			end
			ffha_pkg::OP_DN_RD: begin
				raddr = IW'(ptr_q + CW'(1));
			end
			ffha_pkg::OP_PREV_RD: begin
				raddr = idx_q - IW'(1);
			end
			ffha_pkg::OP_PREV_MERGE: begin
				if (rd_free) begin
					we    = 1'b1;
					waddr = idx_q - IW'(1);
					wdata = {rd_off, BW'(XW'(rd_len) + XW'(cur_len_q) +
						XW'(HEADER_BYTES)), 1'b1};
				end
			end
			ffha_pkg::OP_REL_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ffha_pkg::OP_ACCEPT: begin
				mode_q <= in_mode;
				size_q <= rsum & ~SW'(ffha_pkg::GRANULE_BYTES - 1);
				gp_q   <= gsum[SW-1:ffha_pkg::PAGE_SHIFT];
				tgt_q  <= in_addr - base_h_q;
				idx_q  <= '0;
			end
			ffha_pkg::OP_RESCAN: begin
				idx_q <= '0;
			end
			ffha_pkg::OP_SCAN: begin
				cur_off_q <= rd_off;
				cur_len_q <= rd_len;
				if (!stat.hit) begin
					idx_q <= idx_q + IW'(1);
				end
			end
			ffha_pkg::OP_HIT: begin
				split_q <= stat.split;
				ptr_q   <= count_q;
			end
			ffha_pkg::OP_UP_WR: begin
				ptr_q <= ptr_q - CW'(1);
			end
			ffha_pkg::OP_DN_WR: begin
				ptr_q <= ptr_q + CW'(1);
			end
			ffha_pkg::OP_NEXT_MERGE: begin
				if (rd_free) begin
					cur_len_q <= BW'(XW'(cur_len_q) + XW'(rd_len) + XW'(HEADER_BYTES));
					ptr_q     <= idx_p1;
				end
			end
			ffha_pkg::OP_PREV_MERGE: begin
				ptr_q <= idx_x;
			end
			default: begin
			end
		endcase
	end

	// control state, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_h_q     <= AW'(HEADER_BYTES);
			init_q       <= PCW'(1);
			max_q        <= PCW'(256);
			pend_q       <= 1'b1;
			count_q      <= CW'(1);
			pages_q      <= PW'(1);
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_status_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ffha_pkg::CFG_HEAP_BASE: begin
						base_h_q <= cfg_data + AW'(HEADER_BYTES);
						pend_q   <= 1'b1;
					end
					ffha_pkg::CFG_INITIAL_PAGES: begin
						init_q <= cfg_data[PCW-1:0];
						pend_q <= 1'b1;
					end
					ffha_pkg::CFG_MAX_PAGES: begin
						max_q <= cfg_data[PCW-1:0];
					end
					default: begin
					end
				endcase
			end
			// drop the word once taken, unless a new one replaces it
			if (out_valid_q && out_ready && (cmd.op != ffha_pkg::OP_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				ffha_pkg::OP_INIT: begin
					if (!reinit_wr) begin
						pend_q <= 1'b0;
					end
					count_q <= CW'(1);
					pages_q <= ip;
				end
				ffha_pkg::OP_GROW: begin
					if (stat.grow_ok) begin
						pages_q <= PW'(KW'(pages_q) + KW'(gp_q));
						if (!rd_free) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ffha_pkg::OP_SPLIT_WR: begin
					count_q <= count_q + CW'(1);
				end
				ffha_pkg::OP_DN_END: begin
					count_q <= count_q - CW'(1);
				end
				ffha_pkg::OP_EMIT: begin
					if (stat.out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= cmd.code;
						out_addr_q   <= (cmd.code == ffha_pkg::RES_ALLOCATED) ?
							(base_h_q + AW'(cur_off_q)) : '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_addr   = out_addr_q;
	assign out_status = out_status_q;
endmodule

// ===== src/ffha_checker.sv =====
// ffha_checker: port-level assertions for first_fit_heap_allocator, with its bind.
// Depends on ffha_pkg for result codes.
module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ffha_pkg::ADDR_W-1:0] out_addr,
	input logic [2:0]                  out_status
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_addr) && $stable(out_status))
		else $error("response changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while one is in progress");

	a_addr_only_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ffha_pkg::RES_ALLOCATED) |-> out_addr == '0)
		else $error("address given without allocation");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_addr   (rsp.block_address),
	.out_status (rsp.status)
);

// ===== sim/tb.sv =====
// tb: self-checking bench for first_fit_heap_allocator, with its own heap predictor.
// Depends on ffha_pkg, ffha_if and the allocator RTL; needs no other files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HDR       = 32;
	localparam int SEGS      = 256;
	localparam int PAGES_CAP = 256;
	localparam int AW        = ffha_pkg::ADDR_W;
	localparam int RW        = ffha_pkg::REQ_W;
	localparam int PGB       = ffha_pkg::PAGE_BYTES;
	localparam int GRB       = ffha_pkg::GRANULE_BYTES;
	localparam int PCW       = ffha_pkg::PCFG_W;
	localparam longint CYCLE_LIMIT = 20_000_000;

	// One expected response word.
	typedef struct {
		logic [AW-1:0]       addr;
		ffha_pkg::res_code_t code;
	} heap_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index = ffha_pkg::CFG_HEAP_BASE;
	logic [ffha_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	ffha_req_if req ();
	ffha_rsp_if rsp ();

	first_fit_heap_allocator #(
		.MAX_PAGES(PAGES_CAP), .MAX_SEGMENTS(SEGS), .HEADER_BYTES(HDR)
	) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Heap mirror: segment table in address order plus register copies.
	int unsigned   seg_off [SEGS];
	int unsigned   seg_len [SEGS];
	bit            seg_free [SEGS];
	int unsigned   seg_cnt;
	int unsigned   pages_used;
	logic [AW-1:0] base_reg;
	int unsigned   init_reg;
	int unsigned   limit_reg;

	heap_reply_t   pending_replies[$];
	logic [AW-1:0] live_blocks[$];
	int unsigned   errors = 0;
	longint        cycles = 0;
	int unsigned   burst_left = 0;

	function automatic int unsigned clamp_pg(int unsigned p);
		if (p == 0) return 1;
		if (p > PAGES_CAP) return PAGES_CAP;
		return p;
	endfunction

	function automatic void rebuild_heap();
		pages_used = clamp_pg(init_reg);
		seg_cnt = 1;
		seg_off[0] = 0;
		seg_len[0] = pages_used * PGB - HDR;
		seg_free[0] = 1'b1;
	endfunction

	function automatic void drop_seg(int unsigned i);
		for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
			seg_off[k] = seg_off[k+1];
			seg_len[k] = seg_len[k+1];
			seg_free[k] = seg_free[k+1];
		end
		seg_cnt--;
	endfunction

	function automatic void add_seg(int unsigned i, int unsigned off, int unsigned len, bit fr);
		for (int unsigned k = seg_cnt; k > i; k--) begin
			seg_off[k] = seg_off[k-1];
			seg_len[k] = seg_len[k-1];
			seg_free[k] = seg_free[k-1];
		end
		seg_off[i] = off;
		seg_len[i] = len;
		seg_free[i] = fr;
		seg_cnt++;
	endfunction

	function automatic logic [AW-1:0] payload_of(int unsigned i);
		return base_reg + AW'(seg_off[i]) + AW'(HDR);
	endfunction

	function automatic int first_fit(int unsigned sz);
		for (int unsigned i = 0; i < seg_cnt; i++)
			if (seg_free[i] && seg_len[i] >= sz) return int'(i);
		return -1;
	endfunction

	function automatic bit extend_heap(int unsigned sz);
		int unsigned pg;
		int unsigned last;
		pg = (sz + PGB - 1) / PGB;
		last = seg_cnt - 1;
		if (pg == 0) pg = 1;
		if (pages_used + pg > clamp_pg(limit_reg)) return 1'b0;
		if (seg_free[last])
			seg_len[last] += pg * PGB;
		else if (seg_cnt < SEGS)
			add_seg(seg_cnt, pages_used * PGB, pg * PGB - HDR, 1'b1);
		else
			return 1'b0;
		pages_used += pg;
		return 1'b1;
	endfunction

	// Advance the mirror by one request and return the reply it must produce.
	function automatic heap_reply_t heap_predict(logic mode, logic [RW-1:0] size,
			logic [AW-1:0] target);
		heap_reply_t r;
		int unsigned sz;
		int f;
		r.addr = '0;
		if (!mode) begin
			sz = (int'(size) + GRB - 1) & ~(GRB - 1);
			if (sz == 0) begin
				r.code = ffha_pkg::RES_ZERO_SIZE;
				return r;
			end
			r.code = ffha_pkg::RES_ALLOCATED;
			forever begin
				f = first_fit(sz);
				if (f >= 0) break;
				if (!extend_heap(sz)) begin
					r.code = ffha_pkg::RES_NO_MEMORY;
					break;
				end
			end
			if (f >= 0) begin
				// split only when the tail can hold a header and a granule
				if (seg_cnt < SEGS && seg_len[f] >= sz + HDR + GRB) begin
					add_seg(f + 1, seg_off[f] + HDR + sz, seg_len[f] - sz - HDR, 1'b1);
					seg_len[f] = sz;
				end
				seg_free[f] = 1'b0;
				r.addr = payload_of(f);
			end
		end else begin
			r.code = ffha_pkg::RES_BAD_ADDRESS;
			for (int unsigned i = 0; i < seg_cnt; i++) begin
				if (payload_of(i) == target) begin
					seg_free[i] = 1'b1;
					// merge forward first, then backward
					if (i + 1 < seg_cnt && seg_free[i+1]) begin
						seg_len[i] += seg_len[i+1] + HDR;
						drop_seg(i + 1);
					end
					if (i > 0 && seg_free[i-1]) begin
						seg_len[i-1] += seg_len[i] + HDR;
						drop_seg(i);
					end
					r.code = ffha_pkg::RES_RELEASED;
					break;
				end
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [AW-1:0] got, logic [AW-1:0] want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
		errors++;
	endtask

	// Send one request word with burst/gap shaping; predict it on acceptance.
	task automatic send_word(logic mode, logic [RW-1:0] size, logic [AW-1:0] target);
		heap_reply_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.mode <= mode;
		req.request_size <= size;
		req.release_address <= target;
		do @(posedge clk); while (!req.ready);
		r = heap_predict(mode, size, target);
		pending_replies.push_back(r);
		if (r.code == ffha_pkg::RES_ALLOCATED) live_blocks.push_back(r.addr);
	endtask

	// Hold off the sender until every expected word is back.
	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [ffha_pkg::CFG_IDX_W-1:0] idx,
			logic [ffha_pkg::CFG_DATA_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			ffha_pkg::CFG_HEAP_BASE: begin
				base_reg = val;
				rebuild_heap();
				live_blocks.delete();
			end
			ffha_pkg::CFG_INITIAL_PAGES: begin
				init_reg = 32'(val[PCW-1:0]);
				rebuild_heap();
				live_blocks.delete();
			end
			default: limit_reg = 32'(val[PCW-1:0]);
		endcase
	endtask

	task automatic release_live(int unsigned k);
		logic [AW-1:0] a;
		a = live_blocks[k];
		live_blocks.delete(k);
		send_word(1'b1, '0, a);
	endtask

	// Hand-picked cases: size extremes, rounding, growth, bad and double release,
	// coalescing on both sides.
	task automatic test_directed();
		logic [AW-1:0] a0, a1, a2;
		send_word(1'b0, 21'd0, '1);
		send_word(1'b0, 21'd1, '0);
		a0 = live_blocks[live_blocks.size()-1];
		send_word(1'b0, 21'd16, '0);
		a1 = live_blocks[live_blocks.size()-1];
		send_word(1'b0, 21'd17, '0);
		a2 = live_blocks[live_blocks.size()-1];
		send_word(1'b0, 21'd1048576, '0);
		send_word(1'b0, 21'h0FFFFF, '0);
		send_word(1'b1, 21'h1FFFFF, 48'hFFFF_FFFF_FFFF);
		send_word(1'b1, '0, a0 + 48'd16);
		send_word(1'b1, '0, a0);
		send_word(1'b1, '0, a0);
		send_word(1'b1, '0, a2);
		send_word(1'b1, '0, a1);
		send_word(1'b0, 21'd4000, '0);
		send_word(1'b0, 21'd9000, '0);
		send_word(1'b0, 21'd500000, '0);
		live_blocks.delete();
	endtask

	// Fill the segment table, run past it, then free everything in random order.
	task automatic test_table_full();
		write_reg(ffha_pkg::CFG_INITIAL_PAGES, 48'd1);
		for (int n = 0; n < 290; n++)
			send_word(1'b0, 21'($urandom_range(1, 48)), '0);
		while (live_blocks.size() != 0)
			release_live($urandom_range(0, live_blocks.size() - 1));
	endtask

	// Random mix; mostly valid allocate/release traffic, some noise.
	task automatic test_random(int unsigned n);
		int unsigned pick;
		logic [RW-1:0] sz;
		for (int unsigned k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50 || (pick < 85 && live_blocks.size() == 0)) begin
				case ($urandom_range(0, 9))
					0: sz = 21'($urandom_range(4097, 70000));
					1: sz = $urandom_range(0, 15) == 0 ? 21'd1048576 : 21'($urandom());
					default: sz = 21'($urandom_range(1, 600));
				endcase
				if (sz > 21'd1048576) sz = 21'd1048576;
				send_word(1'b0, sz, AW'({$urandom(), $urandom()}));
			end else if (pick < 85) begin
				release_live($urandom_range(0, live_blocks.size() - 1));
			end else if (pick < 92) begin
				send_word(1'b1, 21'($urandom()), AW'({$urandom(), $urandom()}));
			end else begin
				send_word(1'b0, '0, '0);
			end
		end
	endtask

	// Receiver: check each accepted word, then pick the next ready level.
	int unsigned stall_style = 0;
	always @(posedge clk) begin
		heap_reply_t w;
		cycles <= cycles + 1;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_replies.size() == 0) begin
				report("unexpected word, status", AW'(rsp.status), '0);
			end else begin
				w = pending_replies.pop_front();
				if (rsp.block_address !== w.addr)
					report("block_address", rsp.block_address, w.addr);
				if (rsp.status !== w.code)
					report("status", AW'(rsp.status), AW'(w.code));
			end
		end
		if (cycles % 200 == 0) stall_style = $urandom_range(0, 2);
		case (stall_style)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= $urandom_range(0, 1);
			default: rsp.ready <= ($urandom_range(0, 5) == 0);
		endcase
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.mode = 1'b0;
		req.request_size = '0;
		req.release_address = '0;
		rsp.ready = 1'b0;
		base_reg = '0;
		init_reg = 1;
		limit_reg = 256;
		rebuild_heap();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_full();
		test_random(150);
		// top-of-space base: payload addresses wrap past 2^48
		write_reg(ffha_pkg::CFG_HEAP_BASE, 48'hFFFF_FFFF_FFE0);
		write_reg(ffha_pkg::CFG_MAX_PAGES, 48'd256);
		test_random(100);
		// tight growth limit: frequent out-of-memory
		write_reg(ffha_pkg::CFG_HEAP_BASE, AW'({$urandom(), $urandom()}));
		write_reg(ffha_pkg::CFG_INITIAL_PAGES, 48'd2);
		write_reg(ffha_pkg::CFG_MAX_PAGES, 48'd4);
		test_random(100);
		// zero page counts act as one page
		write_reg(ffha_pkg::CFG_MAX_PAGES, 48'd0);
		write_reg(ffha_pkg::CFG_INITIAL_PAGES, 48'd0);
		test_random(80);
		// counts past the cap act as the cap
		write_reg(ffha_pkg::CFG_MAX_PAGES, 48'h1FF);
		write_reg(ffha_pkg::CFG_INITIAL_PAGES, 48'd300);
		test_random(80);
		write_reg(ffha_pkg::CFG_INITIAL_PAGES, 48'd256);
		write_reg(ffha_pkg::CFG_HEAP_BASE, 48'h0);
		test_random(80);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_ram.sv
src/ffha_ctrl.sv
src/ffha_dp.sv
src/first_fit_heap_allocator.sv
src/ffha_checker.sv
sim/tb.sv
